// ===== rtl/core/gsd_pkg.sv =====
// Package for the grid swap distance block: widths, register indexes, control types.
package gsd_pkg;

	localparam int MAX_STEPS_DEF = 64;
	localparam int MAX_SIDE_DEF  = 32;

	localparam int POS_W  = 10;
	localparam int SIDE_W = 6;
	localparam int RSQ_W  = 7;
	localparam int DIST_W = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 7;
	localparam int FLD_W = 5;
	localparam int ENT_W = 2 * FLD_W;
	localparam int CNT_W = 7;

	// largest step component possible with a 7-bit radius squared
	localparam int A_MAX = 11;
	localparam int AC_W  = 4;

	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 2'd2;

	localparam logic [SIDE_W-1:0] COLUMNS_RST = 6'd8;
	localparam logic [SIDE_W-1:0] ROWS_RST    = 6'd8;
	localparam logic [RSQ_W-1:0]  RADIUS_RST  = 7'd4;

	typedef struct packed {
		logic bld_start;
		logic bld_step;
		logic accept;
		logic div_step;
		logic walk_start;
		logic sub_step;
		logic out_load;
	} gsd_cmd_t;

	typedef struct packed {
		logic bld_last;
		logic div_last;
		logic bad;
		logic empty;
		logic fits;
		logic k_last;
	} gsd_stat_t;

	// {found, root} when v is a perfect square of a value up to A_MAX
	function automatic logic [AC_W:0] exact_root(input logic [RSQ_W-1:0] v);
		logic [AC_W:0] r;
		r = '0;
		for (int i = 0; i <= A_MAX; i++) begin
			if (8'(i * i) == {1'b0, v})
				r = {1'b1, AC_W'(i)};
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/gsd_ram.sv =====
// Generic single-port-write, registered-read RAM.
module gsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/gsd_ctrl.sv =====
// Sequencer for table build, position split and greedy walk.
module gsd_ctrl import gsd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  gsd_stat_t st,
	output gsd_cmd_t  cmd
);
	localparam logic [2:0] S_INIT  = 3'd0;
	localparam logic [2:0] S_BUILD = 3'd1;
	localparam logic [2:0] S_IDLE  = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_WST   = 3'd4;
	localparam logic [2:0] S_WAIT  = 3'd5;
	localparam logic [2:0] S_SUB   = 3'd6;
	localparam logic [2:0] S_FIN   = 3'd7;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.bld_start = 1'b1;
				state_d = S_BUILD;
			end
			S_BUILD: begin
				if (cfg_we) begin
					state_d = S_INIT;
				end else begin
					cmd.bld_step = 1'b1;
					if (st.bld_last)
						state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (cfg_we) begin
					state_d = S_INIT;
				end else if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (st.bad) begin
					state_d = S_FIN;
				end else begin
					cmd.div_step = 1'b1;
					if (st.div_last)
						state_d = S_WST;
				end
			end
			S_WST: begin
				cmd.walk_start = 1'b1;
				state_d = st.empty ? S_FIN : S_WAIT;
			end
			S_WAIT: state_d = S_SUB;
			S_SUB: begin
				cmd.sub_step = 1'b1;
				if (!st.fits)
					state_d = st.k_last ? S_FIN : S_WAIT;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == S_IDLE) && !cfg_we;
	assign out_valid = out_valid_q;
endmodule

// ===== rtl/core/gsd_dp.sv =====
// Datapath: config registers, step table, dividers, greedy walk, result word.
module gsd_dp import gsd_pkg::*; #(
	parameter int MAX_STEPS = MAX_STEPS_DEF,
	parameter int MAX_SIDE  = MAX_SIDE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic [POS_W-1:0]     position_a,
	input  logic [POS_W-1:0]     position_b,
	output logic [DIST_W-1:0]    swap_distance,
	output logic                 bad_request,
	input  gsd_cmd_t             cmd,
	output gsd_stat_t            st
);
	localparam int AW = $clog2(MAX_STEPS);
	localparam int CW = $clog2(MAX_STEPS + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_STEPS);
	localparam logic [CW-1:0] TOP  = CW'(MAX_STEPS - 1);

	logic [SIDE_W-1:0] cols_q, rows_q, eff_c, eff_r;
	logic [RSQ_W-1:0]  r2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= COLUMNS_RST;
			rows_q <= ROWS_RST;
			r2_q   <= RADIUS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLUMNS: cols_q <= cfg_data[SIDE_W-1:0];
				REG_ROWS:    rows_q <= cfg_data[SIDE_W-1:0];
				REG_RADIUS:  r2_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign eff_c = (32'(cols_q) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : cols_q;
	assign eff_r = (32'(rows_q) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : rows_q;

	// table build: shortest vectors first, stored from the top entry down
	logic [RSQ_W-1:0] len_q;
	logic [AC_W-1:0]  ba_q;
	logic [CW-1:0]    fill_q;
	logic [7:0]       asq;
	logic [7:0]       rem8;
	logic [AC_W:0]    root;
	logic [SIDE_W-1:0] ca, cb;
	logic             qual, we;
	logic [CW-1:0]    waddr_w;
	logic [ENT_W-1:0] rdata;

	assign asq  = 8'(ba_q * ba_q);
	assign rem8 = {1'b0, len_q} - asq;
	assign root = exact_root(rem8[RSQ_W-1:0]);
	assign ca   = {{(SIDE_W-AC_W){1'b0}}, ba_q};
	assign cb   = {{(SIDE_W-AC_W){1'b0}}, root[AC_W-1:0]};

	always_comb begin
		if (ca == '0 && cb == '0)
			qual = 1'b0;
		else if (ca <= cb)
			qual = (ca < eff_c) && (cb < eff_r);
		else
			qual = (cb < eff_c) && (ca < eff_r);
	end

	assign we = cmd.bld_step && (len_q <= r2_q) && (asq <= {1'b0, len_q}) && root[AC_W]
		&& qual && (fill_q != FULL);
	assign waddr_w = TOP - fill_q;
	assign st.bld_last = (r2_q == '0) || (fill_q == FULL)
		|| ((len_q >= r2_q) && (ba_q == AC_W'(A_MAX)));

	// position split by restoring division, one bit a cycle for both
	logic [POS_W-1:0]  diva_q, divb_q, qa_q, qb_q;
	logic [SIDE_W-1:0] ra_q, rb_q;
	logic [3:0]        dcnt_q;
	logic              bad_q;
	logic [SIDE_W:0]   ta, tb;
	logic              ga, gb;
	logic [11:0]       cells;

	assign ta = {ra_q, diva_q[POS_W-1]};
	assign tb = {rb_q, divb_q[POS_W-1]};
	assign ga = (ta >= {1'b0, eff_c});
	assign gb = (tb >= {1'b0, eff_c});
	assign cells = 12'(eff_c * eff_r);
	assign st.div_last = (dcnt_q == 4'(POS_W - 1));
	assign st.bad = bad_q;

	// greedy walk
	logic [CW-1:0]     k_q;
	logic [SIDE_W-1:0] dx_q, dy_q, sa, sb;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  cm1;
	logic [DIST_W-1:0] res;

	assign sa = {1'b0, rdata[FLD_W-1:0]};
	assign sb = {1'b0, rdata[ENT_W-1:FLD_W]};
	assign st.fits   = (dx_q >= sa) && (dy_q >= sb);
	assign st.k_last = (k_q == TOP);
	assign st.empty  = (fill_q == '0);
	assign cm1 = count_q - 1'b1;
	assign res = (count_q == '0 || cm1 > CNT_W'(63)) ? DIST_W'(63) : cm1[DIST_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= 7'd1;
			ba_q   <= '0;
			fill_q <= '0;
		end else if (cmd.bld_start) begin
			len_q  <= 7'd1;
			ba_q   <= '0;
			fill_q <= '0;
		end else if (cmd.bld_step) begin
			if (we)
				fill_q <= fill_q + 1'b1;
			if (ba_q == AC_W'(A_MAX)) begin
				ba_q  <= '0;
				len_q <= len_q + 1'b1;
			end else begin
				ba_q <= ba_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			diva_q <= position_a;
			divb_q <= position_b;
			ra_q   <= '0;
			rb_q   <= '0;
			dcnt_q <= '0;
			bad_q  <= (eff_c == '0) || (eff_r == '0) || ({2'b0, position_a} >= cells)
				|| ({2'b0, position_b} >= cells) || (position_a == position_b);
		end else if (cmd.div_step) begin
			diva_q <= {diva_q[POS_W-2:0], 1'b0};
			divb_q <= {divb_q[POS_W-2:0], 1'b0};
			qa_q   <= {qa_q[POS_W-2:0], ga};
			qb_q   <= {qb_q[POS_W-2:0], gb};
			ra_q   <= ga ? SIDE_W'(ta - {1'b0, eff_c}) : ta[SIDE_W-1:0];
			rb_q   <= gb ? SIDE_W'(tb - {1'b0, eff_c}) : tb[SIDE_W-1:0];
			dcnt_q <= dcnt_q + 1'b1;
		end
		if (cmd.walk_start) begin
			dx_q    <= (ra_q > rb_q) ? ra_q - rb_q : rb_q - ra_q;
			dy_q    <= (qa_q > qb_q) ? SIDE_W'(qa_q - qb_q) : SIDE_W'(qb_q - qa_q);
			k_q     <= FULL - fill_q;
			count_q <= '0;
		end else if (cmd.sub_step) begin
			if (st.fits) begin
				dx_q    <= dx_q - sa;
				dy_q    <= dy_q - sb;
				count_q <= count_q + 1'b1;
			end else begin
				k_q <= k_q + 1'b1;
			end
		end
		if (cmd.out_load) begin
			swap_distance <= bad_q ? '0 : res;
			bad_request   <= bad_q;
		end
	end

	gsd_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_STEPS)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr_w[AW-1:0]),
		.wdata({1'b0, root[AC_W-1:0], 1'b0, ba_q}),
		.raddr(k_q[AW-1:0]),
		.rdata(rdata)
	);
endmodule

// ===== rtl/core/grid_swap_distance_top.sv =====
// Top level of the grid swap distance block.
//  channel  dir  handshake              word
//  in       in   in_valid / in_ready    position_a, position_b
//  out      out  out_valid / out_ready  swap_distance, bad_request
//  cfg      in   cfg_we                 cfg_index, cfg_data
// A result is produced by the bit-serial position divider and then the walk over the table
// RAM; an off-grid or equal pair skips both. The next word is taken in the idle state once
// the result is loaded. After reset and after each register write while idle or building,
// the step table is rebuilt, one (length, component) candidate a cycle, no input taken.
// One word is in flight; a held result stalls only the finish of the next word.
module grid_swap_distance_top import gsd_pkg::*; #(
	parameter int MAX_STEPS = MAX_STEPS_DEF,
	parameter int MAX_SIDE  = MAX_SIDE_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [POS_W-1:0]     position_a,
	input  logic [POS_W-1:0]     position_b,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DIST_W-1:0]    swap_distance,
	output logic                 bad_request
);
	gsd_cmd_t  cmd;
	gsd_stat_t st;

	gsd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.st       (st),
		.cmd      (cmd)
	);

	gsd_dp #(
		.MAX_STEPS(MAX_STEPS),
		.MAX_SIDE (MAX_SIDE)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.position_a   (position_a),
		.position_b   (position_b),
		.swap_distance(swap_distance),
		.bad_request  (bad_request),
		.cmd          (cmd),
		.st           (st)
	);
endmodule

// ===== verif/tb_grid_swap_distance_top.sv =====
// Testbench for grid_swap_distance_top: directed and random position pairs checked against a predictor.
module tb_grid_swap_distance_top;
	import gsd_pkg::*;

	typedef struct packed {
		logic [DIST_W-1:0] dist_v;
		logic              bad;
	} dist_word_t;

	class dist_scoreboard;
		logic [SIDE_W-1:0] cols;
		logic [SIDE_W-1:0] rows;
		logic [RSQ_W-1:0]  rsq;
		logic [4:0]        step_a[MAX_STEPS_DEF];
		logic [4:0]        step_b[MAX_STEPS_DEF];
		int                n_steps;
		dist_word_t        pending[$];
		int                mismatches;
		int                checked;

		function void rebuild();
			int c, r, total, skip, seen;
			c = (cols > MAX_SIDE_DEF) ? MAX_SIDE_DEF : cols;
			r = (rows > MAX_SIDE_DEF) ? MAX_SIDE_DEF : rows;
			total = 0;
			for (int pass = 0; pass < 2; pass++) begin
				skip = (total > MAX_STEPS_DEF) ? total - MAX_STEPS_DEF : 0;
				seen = 0;
				for (int len = rsq; len >= 1; len--)
					for (int a = MAX_SIDE_DEF - 1; a >= 0; a--)
						for (int b = 0; b < MAX_SIDE_DEF; b++) begin
							if (a * a + b * b != len) continue;
							if (a == 0 && b == 0) continue;
							if (a <= b ? !(a < c && b < r) : !(b < c && a < r)) continue;
							if (pass == 1 && seen >= skip && seen - skip < MAX_STEPS_DEF) begin
								step_a[seen - skip] = a[4:0];
								step_b[seen - skip] = b[4:0];
							end
							seen++;
						end
				if (pass == 0) total = seen;
			end
			n_steps = total - skip;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
			case (idx)
				REG_COLUMNS: cols = val[5:0];
				REG_ROWS:    rows = val[5:0];
				REG_RADIUS:  rsq = val;
				default: return;
			endcase
			rebuild();
		endfunction

		function new();
			cols = COLUMNS_RST;
			rows = ROWS_RST;
			rsq = RADIUS_RST;
			mismatches = 0;
			checked = 0;
			rebuild();
		endfunction

		function void note_input(logic [POS_W-1:0] pa, logic [POS_W-1:0] pb);
			int c, r, dx, dy, cnt;
			dist_word_t w;
			c = (cols > MAX_SIDE_DEF) ? MAX_SIDE_DEF : cols;
			r = (rows > MAX_SIDE_DEF) ? MAX_SIDE_DEF : rows;
			if (c == 0 || r == 0 || pa >= c * r || pb >= c * r || pa == pb) begin
				w.dist_v = '0;
				w.bad = 1'b1;
			end else begin
				dx = pa % c - pb % c;
				dy = pa / c - pb / c;
				if (dx < 0) dx = -dx;
				if (dy < 0) dy = -dy;
				cnt = 0;
				for (int k = 0; k < n_steps; k++)
					while (dx >= step_a[k] && dy >= step_b[k]) begin
						cnt++;
						dx -= step_a[k];
						dy -= step_b[k];
					end
				w.dist_v = (cnt == 0 || cnt - 1 > 63) ? 6'd63 : DIST_W'(cnt - 1);
				w.bad = 1'b0;
			end
			pending = {pending, w};
		endfunction

		function void check_result(logic [DIST_W-1:0] dist_v, logic bad);
			dist_word_t e;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word: dist=%0d bad=%0b", dist_v, bad);
				return;
			end
			e = pending.pop_front();
			if (e.dist_v !== dist_v || e.bad !== bad) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected dist=%0d bad=%0b, got dist=%0d bad=%0b",
						e.dist_v, e.bad, dist_v, bad);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [POS_W-1:0] position_a = '0;
	logic [POS_W-1:0] position_b = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DIST_W-1:0] swap_distance;
	logic bad_request;

	dist_scoreboard sb = new();
	int cycles = 0;
	bit calm = 1'b0;
	int gap_left = 0;
	int n_sent = 0;

	always #4 clk = ~clk;

	grid_swap_distance_top u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.position_a(position_a), .position_b(position_b), .out_valid(out_valid),
		.out_ready(out_ready), .swap_distance(swap_distance), .bad_request(bad_request)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("tb_grid_swap_distance_top: errors");
			$finish;
		end
	end

	// receiver with random stall bursts
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(swap_distance, bad_request);
		if (gap_left > 0) begin
			gap_left <= gap_left - 1;
			out_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			gap_left <= $urandom_range(0, 2);
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	task automatic send_word(logic [POS_W-1:0] pa, logic [POS_W-1:0] pb);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		position_a <= pa;
		position_b <= pb;
		do @(posedge clk); while (!in_ready);
		sb.note_input(pa, pb);
		n_sent++;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
		cfg_we <= 1'b0;
	endtask

	task automatic send_in_grid(int k);
		int area;
		area = sb.cols * sb.rows;
		repeat (k) begin
			if (area == 0 || $urandom_range(0, 9) == 0)
				send_word(POS_W'($urandom_range(0, 1023)), POS_W'($urandom_range(0, 1023)));
			else
				send_word(POS_W'($urandom_range(0, area - 1)),
					POS_W'($urandom_range(0, area - 1)));
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset config: corners, equal, off grid, extremes
		send_word(0, 63);
		send_word(7, 56);
		send_word(5, 5);
		send_word(0, 64);
		send_word(1023, 0);
		send_word(0, 1023);
		send_word(1, 0);
		send_word(9, 0);
		send_word(10'h2AA, 10'h155);
		// one row, tiny radius: unreachable vertical step
		write_reg(REG_ROWS, 1);
		write_reg(REG_RADIUS, 1);
		send_word(0, 7);
		write_reg(REG_ROWS, 0);
		send_word(0, 1);
		// oversized grid, max radius; long walks
		write_reg(REG_COLUMNS, 63);
		write_reg(REG_ROWS, 63);
		write_reg(REG_RADIUS, 127);
		send_word(0, 1023);
		send_word(31, 992);
		send_word(0, 31);
		write_reg(3, 5);
		write_reg(REG_RADIUS, 1);
		send_word(0, 1023);
		send_word(0, 31);
		// random phases over settings
		for (int ph = 0; ph < 10; ph++) begin
			write_reg(REG_COLUMNS, CFG_DAT_W'((ph == 0) ? 1 : $urandom_range(0, 63)));
			write_reg(REG_ROWS, CFG_DAT_W'((ph == 1) ? 32 : $urandom_range(0, 63)));
			write_reg(REG_RADIUS, CFG_DAT_W'((ph == 2) ? 64 : $urandom_range(1, 127)));
			send_in_grid(40);
		end
		calm = 1'b1;
		send_in_grid(130);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		$display("covered %0d words over %0d checked results, grids 0..63 side, radius 1..127",
			n_sent, sb.checked);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("tb_grid_swap_distance_top: clean");
		else
			$display("tb_grid_swap_distance_top: errors");
		$finish;
	end
endmodule
